// ===== sv/sha256_byte_stream_hasher_defines.svh =====
// Assertion macros for the SHA-256 byte stream hasher.
// Used by sha256_byte_stream_hasher.sv; expects clk and rst_n in scope.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define SBH_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SBH_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/sbh_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
// No dependencies; imported by sha256_byte_stream_hasher.
`default_nettype none

package sbh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

// ===== sv/sha256_byte_stream_hasher.sv =====
// A byte word is taken in idle on each handshake; every 64th byte starts the rounds of the block, then the add.
// On last: pad bytes fill each padded block (1 or 2 blocks), each runs rounds and add, then 8 out words follow.
// No bytes are taken during the 64 rounds and the add of a block, as there is a single round unit.
// Reset (synchronous, rst_n low): hash to initial values, fill and length counters cleared.
// No clearing pass: the block buffer is always written before it is read.
// Depends on sbh_pkg and sha256_byte_stream_hasher_defines.svh.
`default_nettype none
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbh_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbh_pkg::out_word_t  out_data
);
  import sbh_pkg::*;

  state_t        state_r, state_nxt;
  logic [511:0]  blk_r, blk_nxt;
  logic [5:0]    fill_r, fill_nxt;
  logic [60:0]   tot_r, tot_nxt;
  logic [63:0]   len_r, len_nxt;
  logic [31:0]   hash_r [8];
  logic [31:0]   hash_nxt [8];
  logic [31:0]   v_r [8];
  logic [31:0]   v_nxt [8];
  logic [5:0]    rnd_r, rnd_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic          fin_r, fin_nxt;
  logic          p80_r, p80_nxt;
  logic          lm_r, lm_nxt;
  logic          done_r, done_nxt;

  logic          in_acc, out_acc, out_end;
  logic          shift_en, blk_full, len_sel;
  logic [7:0]    shift_byte;
  logic [31:0]   w_cur, w_new, t1, t2;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign out_end = out_acc && (idx_r == 3'd7);

  assign w_cur = blk_r[511:480];
  assign w_new = blk_r[511:480] + small_sig0(blk_r[479:448]) + blk_r[223:192]
                 + small_sig1(blk_r[63:32]);
  assign t1 = v_r[7] + big_sig1(v_r[4]) + choose(v_r[4], v_r[5], v_r[6])
              + ROUND_K[rnd_r] + w_cur;
  assign t2 = big_sig0(v_r[0]) + majority(v_r[0], v_r[1], v_r[2]);

  always_comb begin
    shift_en   = 1'b0;
    len_sel    = 1'b0;
    shift_byte = in_data.data_byte;
    if (state_r == ST_IDLE) begin
      shift_en = in_acc && in_data.byte_present;
    end else if (state_r == ST_PAD) begin
      shift_en = 1'b1;
      if (!p80_r) begin
        shift_byte = PAD_BYTE;
      end else if (lm_r && (fill_r >= LEN_POS)) begin
        len_sel    = 1'b1;
        shift_byte = len_r[63:56];
      end else begin
        shift_byte = 8'h00;
      end
    end
  end

  assign blk_full = shift_en && (fill_r == 6'd63);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (blk_full) begin
            state_nxt = ST_ROUND;
          end else if (in_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (done_r) begin
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready             = 1'b0;
    out_valid            = 1'b0;
    out_data.digest_word = hash_r[idx_r];
    out_data.word_index  = idx_r;
    out_data.digest_last = (idx_r == 3'd7);
    unique case (state_r) inside
      ST_IDLE:  in_ready  = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      ST_ROUND, ST_ADD, ST_PAD: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    blk_nxt  = blk_r;
    fill_nxt = fill_r;
    tot_nxt  = tot_r;
    len_nxt  = len_r;
    rnd_nxt  = 6'd0;
    idx_nxt  = idx_r;
    fin_nxt  = fin_r;
    p80_nxt  = p80_r;
    lm_nxt   = lm_r;
    done_nxt = done_r;
    hash_nxt = hash_r;
    v_nxt    = v_r;

    if (shift_en) begin
      blk_nxt  = {blk_r[503:0], shift_byte};
      fill_nxt = fill_r + 6'd1;
    end else if (state_r == ST_ROUND) begin
      blk_nxt = {blk_r[479:0], w_new};
    end

    if (in_acc && in_data.byte_present) begin
      tot_nxt = tot_r + 61'd1;
    end
    if (in_acc && in_data.last) begin
      fin_nxt = 1'b1;
      len_nxt = {tot_nxt, 3'b000};
    end
    if (len_sel) begin
      len_nxt = {len_r[55:0], 8'h00};
    end

    if ((state_r == ST_PAD) && !p80_r) begin
      p80_nxt = 1'b1;
      if (fill_r < LEN_POS) begin
        lm_nxt = 1'b1;
      end
    end
    if ((state_r == ST_ADD) && fin_r) begin
      lm_nxt = 1'b1;
    end
    if ((state_r == ST_PAD) && blk_full && lm_r) begin
      done_nxt = 1'b1;
    end

    if ((state_nxt == ST_ROUND) && (state_r != ST_ROUND)) begin
      v_nxt = hash_r;
    end else if (state_r == ST_ROUND) begin
      rnd_nxt  = rnd_r + 6'd1;
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end

    if (state_r == ST_ADD) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + v_r[i];
      end
    end

    if (out_acc) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (out_end) begin
      hash_nxt = H_INIT;
      tot_nxt  = '0;
      fill_nxt = '0;
      fin_nxt  = 1'b0;
      p80_nxt  = 1'b0;
      lm_nxt   = 1'b0;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      tot_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      p80_r   <= 1'b0;
      lm_r    <= 1'b0;
      done_r  <= 1'b0;
      hash_r  <= H_INIT;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      tot_r   <= tot_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      p80_r   <= p80_nxt;
      lm_r    <= lm_nxt;
      done_r  <= done_nxt;
      hash_r  <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    len_r <= len_nxt;
    v_r   <= v_nxt;
  end

  `SBH_ASSERT_NEXT(a_round_end, (state_r == ST_ROUND) && (rnd_r == 6'd63), state_r == ST_ADD, "round count did not end in add")
  `SBH_ASSERT_NEXT(a_restart, out_valid && out_ready && out_data.digest_last, in_ready && (fill_r == 6'd0) && (tot_r == '0), "no clean restart after digest")
  `SBH_ASSERT_NOW(a_one_side, out_valid, !in_ready, "input open while digest pending")
  `SBH_ASSERT_NOW(a_final_block, done_r, fin_r && lm_r && p80_r, "final block without padding")

endmodule

`default_nettype wire
